[hdl/dcrc8_pkg.sv]
// types, constants and the byte-wide crc step for the datagram crc8 block
// no dependencies
package dcrc8_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'hD5;
    localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;
    localparam logic [BYTE_W-1:0] AUG_BYTE = 8'h00;

    typedef enum logic
    {
        MODE_CHECK = 1'b0,
        MODE_GEN   = 1'b1
    } mode_t;

    typedef struct packed
    {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
        logic              crc_match;
    } res_t;

    typedef struct packed
    {
        logic busy;
        logic last;
        logic crc_zero;
    } stat_t;

    // msb-first shift of one byte into the register, unrolls to xor logic
    function automatic logic [BYTE_W-1:0] crc_shift_byte(
        input logic [BYTE_W-1:0] r,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] dat;
        logic              top;
        acc = r;
        dat = b;
        for (int i = 0; i < BYTE_W; i++)
        begin
            top = |(acc & CRC_TOP);
            acc = {acc[BYTE_W-2:0], |(dat & CRC_TOP)};
            dat = {dat[BYTE_W-2:0], 1'b0};
            if (top)
            begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

endpackage

[hdl/dcrc8_in_if.sv]
// byte input channel: valid/ready with data byte and last mark
// depends on dcrc8_pkg
interface dcrc8_in_if;
    logic                           valid;
    logic                           ready;
    logic [dcrc8_pkg::BYTE_W-1:0]   data_byte;
    logic                           last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[hdl/dcrc8_out_if.sv]
// result channel: valid/ready with output byte, last mark and match flag
// depends on dcrc8_pkg
interface dcrc8_out_if;
    logic                           valid;
    logic                           ready;
    logic [dcrc8_pkg::BYTE_W-1:0]   out_byte;
    logic                           out_last;
    logic                           crc_match;

    modport source (output valid, output out_byte, output out_last, output crc_match,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input crc_match,
                    output ready);
endinterface

[hdl/dcrc8_cfg_if.sv]
// configuration write channel for the mode register
// no dependencies
interface dcrc8_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/dcrc8_engine.sv]
// input register, running crc register and the per-byte crc logic
// depends on dcrc8_pkg and dcrc8_in_if
module dcrc8_engine
(
    input  logic                    clk,
    input  logic                    rst_n,
    dcrc8_in_if.sink                in_ch,
    input  dcrc8_pkg::mode_t        mode,
    input  logic                    take_ok,
    output logic                    res_valid,
    output dcrc8_pkg::res_t         res,
    output dcrc8_pkg::stat_t        stat
);

    logic                           s1_vld_reg;
    logic                           s1_vld_next;
    logic [dcrc8_pkg::BYTE_W-1:0]   s1_byte_reg;
    logic                           s1_last_reg;
    logic [dcrc8_pkg::BYTE_W-1:0]   crc_reg;
    logic [dcrc8_pkg::BYTE_W-1:0]   crc_next;
    logic [dcrc8_pkg::BYTE_W-1:0]   crc_upd;
    logic [dcrc8_pkg::BYTE_W-1:0]   crc_fin;
    logic                           advance;
    logic                           load;

    assign advance     = s1_vld_reg & take_ok;
    assign in_ch.ready = ~s1_vld_reg | take_ok;
    assign load        = in_ch.valid & in_ch.ready;

    assign crc_upd = dcrc8_pkg::crc_shift_byte(crc_reg, s1_byte_reg);
    assign crc_fin = dcrc8_pkg::crc_shift_byte(crc_reg, dcrc8_pkg::AUG_BYTE);

    always_comb
    begin
        if (load)
        begin
            s1_vld_next = 1'b1;
        end
        else if (advance)
        begin
            s1_vld_next = 1'b0;
        end
        else
        begin
            s1_vld_next = s1_vld_reg;
        end
    end

    // the crc slot itself never enters the register; clear after each frame
    always_comb
    begin
        crc_next = crc_reg;
        if (advance)
        begin
            crc_next = s1_last_reg ? dcrc8_pkg::CRC_INIT : crc_upd;
        end
    end

    always_comb
    begin
        res.out_byte  = s1_byte_reg;
        res.out_last  = s1_last_reg;
        res.crc_match = 1'b0;
        if (s1_last_reg)
        begin
            if (mode == dcrc8_pkg::MODE_GEN)
            begin
                res.out_byte = crc_fin;
            end
            else
            begin
                res.crc_match = (s1_byte_reg == crc_fin);
            end
        end
    end

    assign res_valid     = s1_vld_reg;
    assign stat.busy     = s1_vld_reg;
    assign stat.last     = s1_last_reg;
    assign stat.crc_zero = (crc_reg == dcrc8_pkg::CRC_INIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            crc_reg    <= dcrc8_pkg::CRC_INIT;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            crc_reg    <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_byte_reg <= in_ch.data_byte;
            s1_last_reg <= in_ch.last_byte;
        end
    end

endmodule

[hdl/dcrc8_outreg.sv]
// result register driving the output channel
// depends on dcrc8_pkg and dcrc8_out_if
module dcrc8_outreg
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    res_valid,
    input  dcrc8_pkg::res_t         res,
    output logic                    take_ok,
    dcrc8_out_if.source             out_ch
);

    logic               vld_reg;
    logic               vld_next;
    dcrc8_pkg::res_t    res_reg;
    logic               load;

    assign take_ok = ~vld_reg | out_ch.ready;
    assign load    = res_valid & take_ok;

    always_comb
    begin
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid     = vld_reg;
    assign out_ch.out_byte  = res_reg.out_byte;
    assign out_ch.out_last  = res_reg.out_last;
    assign out_ch.crc_match = res_reg.crc_match;

endmodule

[hdl/datagram_crc8_append_check_core.sv]
// datagram crc8 (poly 0xd5, augmented) generate / check core
// each input beat passes through the input register and then the result register to become a result beat
// throughput: one beat per cycle while out_ch is not stalled; the byte-wide crc update loop is combinational
// reset: rst_n async active low clears both stage valids, the crc register and mode (check)
// depends on dcrc8_pkg, the channel interfaces, dcrc8_engine and dcrc8_outreg
module datagram_crc8_append_check_core
(
    input  logic            clk,
    input  logic            rst_n,
    dcrc8_in_if.sink        in_ch,
    dcrc8_out_if.source     out_ch,
    dcrc8_cfg_if.sink       cfg
);

    dcrc8_pkg::mode_t   mode_reg;
    dcrc8_pkg::res_t    res;
    dcrc8_pkg::stat_t   stat;
    logic               res_valid;
    logic               take_ok;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= dcrc8_pkg::MODE_CHECK;
        end
        else if (cfg.valid)
        begin
            mode_reg <= dcrc8_pkg::mode_t'(cfg.data);
        end
    end

    dcrc8_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .mode      (mode_reg),
        .take_ok   (take_ok),
        .res_valid (res_valid),
        .res       (res),
        .stat      (stat)
    );

    dcrc8_outreg u_outreg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .take_ok   (take_ok),
        .out_ch    (out_ch)
    );

    // a match can only be flagged on the crc slot
    a_match_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.crc_match) |-> out_ch.out_last)
        else $error("crc_match set on a non-last beat");

    // a full pipe with a stalled output must stop taking beats
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.busy && out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
        else $error("input accepted while pipe is full and stalled");

    // crc register clears once the last beat of a frame moves on
    a_crc_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.busy && take_ok && stat.last) |=> stat.crc_zero)
        else $error("crc register not cleared after end of frame");

endmodule
